### design/clbp_pkg.sv
// Shared types and constants of the command line byte parser.
package clbp_pkg;

  localparam logic [2:0] PH_COMMAND   = 3'd0;
  localparam logic [2:0] PH_ARGUMENT  = 3'd1;
  localparam logic [2:0] PH_AFTER_CR  = 3'd2;
  localparam logic [2:0] PH_DONE      = 3'd3;
  localparam logic [2:0] PH_ARG_ERROR = 3'd4;
  localparam logic [2:0] PH_CMD_ERROR = 3'd5;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_ECHO = 2'd1;
  localparam logic [1:0] KIND_GET  = 2'd2;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CASE_MASK = 8'hDF;

  localparam logic [7:0] WORD_ECHO [4] = '{8'h45, 8'h43, 8'h48, 8'h4F};
  localparam logic [7:0] WORD_GET  [3] = '{8'h47, 8'h45, 8'h54};

  typedef struct packed {
    logic [2:0] phase;
    logic [1:0] command_kind;
    logic [6:0] arg_byte;
    logic       arg_valid;
    logic       last;
  } clbp_result_t;

  typedef struct packed {
    logic         push0;
    logic         push1;
    clbp_result_t res0;
    clbp_result_t res1;
  } clbp_push_t;

endpackage

### design/command_line_byte_parser.sv
// Top level of the command line byte parser.
// Parses one text command line ("ECHO <arg>" or "GET <arg>", command word
// case-insensitive, ended by CR LF), one input word per cycle. Each accepted
// word is decided in the cycle it is taken and yields one result word, or two
// (CR then LF) when the argument limit is reached; those results go into a
// four-entry result queue. The input stalls while that queue has fewer than
// two free entries, so with an unstalled output a word is accepted every cycle;
// each result is registered in the queue before it is output. Done and error
// phases hold until reset.
module command_line_byte_parser #(
  parameter int LINE_MAX_BYTES  = 128,
  parameter int CMD_MAX_LETTERS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] phase_o,
  output logic [1:0] command_kind_o,
  output logic [6:0] arg_byte_o,
  output logic       arg_valid_o,
  output logic       last_o
);
  import clbp_pkg::*;

  clbp_push_t   push;
  clbp_result_t out_res;
  logic         accept;

  assign accept = in_valid_i && !in_stall_o;

  clbp_parser #(
    .LINE_MAX_BYTES (LINE_MAX_BYTES),
    .CMD_MAX_LETTERS(CMD_MAX_LETTERS)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_byte_i(in_byte_i),
    .push_o   (push)
  );

  clbp_result_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full2_o    (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_res_o  (out_res)
  );

  assign phase_o        = out_res.phase;
  assign command_kind_o = out_res.command_kind;
  assign arg_byte_o     = out_res.arg_byte;
  assign arg_valid_o    = out_res.arg_valid;
  assign last_o         = out_res.last;

endmodule

### design/clbp_parser.sv
// Parse state and per-word decode; produces one or two results per accepted word.
module clbp_parser #(
  parameter int LINE_MAX_BYTES  = 128,
  parameter int CMD_MAX_LETTERS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          in_byte_i,
  output clbp_pkg::clbp_push_t push_o
);
  import clbp_pkg::*;

  localparam int POS_W    = $clog2(LINE_MAX_BYTES + 1);
  localparam int LIM_ECHO = LINE_MAX_BYTES - CMD_MAX_LETTERS - 1;
  localparam int LIM_GET  = LINE_MAX_BYTES - CMD_MAX_LETTERS - 2;

  logic [2:0]       phase_q, phase_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [1:0]       kind_q, kind_d;
  logic [7:0]       letters_q [4];
  logic             letter_we;
  logic             is_letter, echo_hit, get_hit;
  logic             room_echo, room_get, end_echo, end_get, room, at_end;
  logic [7:0]       emit;
  logic             emit_valid, forced;

  assign is_letter = ((in_byte_i >= CH_UP_A) && (in_byte_i <= CH_UP_Z)) ||
                     ((in_byte_i >= CH_LO_A) && (in_byte_i <= CH_LO_Z));

  assign echo_hit = (pos_q == POS_W'(4)) &&
                    (letters_q[0] == WORD_ECHO[0]) && (letters_q[1] == WORD_ECHO[1]) &&
                    (letters_q[2] == WORD_ECHO[2]) && (letters_q[3] == WORD_ECHO[3]);
  assign get_hit  = (pos_q == POS_W'(3)) &&
                    (letters_q[0] == WORD_GET[0]) && (letters_q[1] == WORD_GET[1]) &&
                    (letters_q[2] == WORD_GET[2]);

  assign room_echo = (LIM_ECHO >= 2) && (int'(pos_q) < LIM_ECHO - 1);
  assign room_get  = (LIM_GET >= 2) && (int'(pos_q) < LIM_GET - 1);
  assign end_echo  = (LIM_ECHO >= 1) && (int'(pos_q) == LIM_ECHO - 1);
  assign end_get   = (LIM_GET >= 1) && (int'(pos_q) == LIM_GET - 1);
  assign room      = (kind_q == KIND_GET) ? room_get : room_echo;
  assign at_end    = (kind_q == KIND_GET) ? end_get : end_echo;

  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    kind_d     = kind_q;
    letter_we  = 1'b0;
    emit       = 8'h00;
    emit_valid = 1'b0;
    forced     = 1'b0;
    unique case (phase_q)
      PH_COMMAND: begin
        if ((pos_q <= POS_W'(CMD_MAX_LETTERS)) && is_letter) begin
          letter_we = 1'b1;
          pos_d     = pos_q + POS_W'(1);
        end else if ((pos_q <= POS_W'(CMD_MAX_LETTERS)) && (in_byte_i == CH_SPACE)) begin
          pos_d = '0;
          if (echo_hit) begin
            kind_d  = KIND_ECHO;
            phase_d = PH_ARGUMENT;
          end else if (get_hit) begin
            kind_d  = KIND_GET;
            phase_d = PH_ARGUMENT;
          end else begin
            phase_d = PH_CMD_ERROR;
          end
        end else begin
          phase_d = PH_CMD_ERROR;
        end
      end
      PH_ARGUMENT: begin
        if (room) begin
          if (!in_byte_i[7]) begin
            emit       = in_byte_i;
            emit_valid = 1'b1;
            pos_d      = pos_q + POS_W'(1);
            phase_d    = (in_byte_i == CH_CR) ? PH_AFTER_CR : PH_ARGUMENT;
          end else begin
            phase_d = PH_ARG_ERROR;
          end
        end else if (at_end) begin
          forced  = 1'b1;
          pos_d   = pos_q + POS_W'(2);
          phase_d = PH_DONE;
        end else begin
          phase_d = PH_ARG_ERROR;
        end
      end
      PH_AFTER_CR: begin
        if (in_byte_i == CH_LF) begin
          emit       = CH_LF;
          emit_valid = 1'b1;
          pos_d      = pos_q + POS_W'(1);
          phase_d    = PH_DONE;
        end else if (in_byte_i == CH_CR) begin
          phase_d = PH_AFTER_CR;
        end else if (!in_byte_i[7]) begin
          phase_d = PH_ARGUMENT;
        end else begin
          phase_d = PH_ARG_ERROR;
        end
      end
      PH_DONE, PH_ARG_ERROR, PH_CMD_ERROR: phase_d = phase_q;
      default: phase_d = PH_ARG_ERROR;
    endcase
  end

  always_comb begin
    push_o.push0 = accept_i;
    push_o.push1 = accept_i && forced;
    if (forced) begin
      push_o.res0 = '{phase: PH_DONE, command_kind: kind_q, arg_byte: CH_CR[6:0],
                      arg_valid: 1'b1, last: 1'b0};
    end else begin
      push_o.res0 = '{phase: phase_d, command_kind: kind_d, arg_byte: emit[6:0],
                      arg_valid: emit_valid, last: 1'b1};
    end
    push_o.res1 = '{phase: PH_DONE, command_kind: kind_q, arg_byte: CH_LF[6:0],
                    arg_valid: 1'b1, last: 1'b1};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_COMMAND;
      pos_q   <= '0;
      kind_q  <= KIND_NONE;
    end else if (accept_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      kind_q  <= kind_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && letter_we && (pos_q < POS_W'(4))) begin
      letters_q[pos_q[1:0]] <= in_byte_i & CASE_MASK;
    end
  end

  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DONE) |=> (phase_q == PH_DONE))
    else $error("done phase left");

  a_kind_in_arg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((phase_q == PH_ARGUMENT) || (phase_q == PH_AFTER_CR)) |->
      ((kind_q == KIND_ECHO) || (kind_q == KIND_GET)))
    else $error("argument phase without a command");

  a_phase_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= PH_CMD_ERROR)
    else $error("unused phase code");

endmodule

### design/clbp_result_fifo.sv
// Four-entry result queue taking up to two results per cycle and giving one when the output is not stalled.
module clbp_result_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  clbp_pkg::clbp_push_t   push_i,
  output logic                   full2_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output clbp_pkg::clbp_result_t out_res_o
);
  import clbp_pkg::*;

  clbp_result_t mem_q [4];
  logic [1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [2:0]   count_q, count_d;
  logic         pop;

  assign out_valid_o = (count_q != 3'd0);
  assign out_res_o   = mem_q[rptr_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign full2_o     = (count_q > 3'd2);

  always_comb begin
    wptr_d  = wptr_q + {1'b0, push_i.push0} + {1'b0, push_i.push1};
    rptr_d  = rptr_q + {1'b0, pop};
    count_d = count_q + {2'b00, push_i.push0} + {2'b00, push_i.push1} - {2'b00, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push0) begin
      mem_q[wptr_q] <= push_i.res0;
    end
    if (push_i.push1) begin
      mem_q[wptr_q + 2'd1] <= push_i.res1;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.push1 |-> (push_i.push0 && (count_q <= 3'd2)))
    else $error("result queue overflow");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Testbench of the command line byte parser: directed and random lines against a predictor.
module tb;
  import clbp_pkg::*;

  localparam int LINE_MAX_BYTES  = 128;
  localparam int CMD_MAX_LETTERS = 8;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int HOLD_CYCLES     = 60;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] in_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [2:0] phase_o;
  logic [1:0] command_kind_o;
  logic [6:0] arg_byte_o;
  logic       arg_valid_o;
  logic       last_o;

  command_line_byte_parser #(
    .LINE_MAX_BYTES (LINE_MAX_BYTES),
    .CMD_MAX_LETTERS(CMD_MAX_LETTERS)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_byte_i     (in_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .phase_o       (phase_o),
    .command_kind_o(command_kind_o),
    .arg_byte_o    (arg_byte_o),
    .arg_valid_o   (arg_valid_o),
    .last_o        (last_o)
  );

  clbp_result_t pending_results [$];
  int           send_idle_pct;
  int           recv_idle_pct;
  bit           hold_output;
  int           mismatches;
  int           cycles;

  logic [2:0] line_phase;
  int         line_pos;
  int         line_limit;
  logic [7:0] cmd_letters [CMD_MAX_LETTERS + 1];
  logic [1:0] line_kind;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= hold_output || ($urandom_range(99) < recv_idle_pct);
  end

  // Expected result words for one accepted input word.
  task automatic predict_parse(input logic [7:0] c);
    clbp_result_t r;
    logic [2:0]   nxt;
    logic [7:0]   emit;
    logic         emit_valid;
    bit           is_echo;
    bit           is_get;
    emit       = '0;
    emit_valid = 1'b0;
    nxt        = line_phase;
    unique case (line_phase)
      PH_COMMAND: begin
        nxt = PH_CMD_ERROR;
        if (line_pos < line_limit + 1 && line_pos <= CMD_MAX_LETTERS) begin
          if ((c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z)) begin
            cmd_letters[line_pos] = c & CASE_MASK;
            line_pos++;
            nxt = PH_COMMAND;
          end else if (c == CH_SPACE) begin
            is_echo = (line_pos == 4);
            for (int i = 0; i < 4; i++)
              if (is_echo && cmd_letters[i] != WORD_ECHO[i]) is_echo = 1'b0;
            is_get = (line_pos == 3);
            for (int i = 0; i < 3; i++)
              if (is_get && cmd_letters[i] != WORD_GET[i]) is_get = 1'b0;
            if (is_echo) begin
              line_kind  = KIND_ECHO;
              line_limit = LINE_MAX_BYTES - CMD_MAX_LETTERS - 1;
              nxt        = PH_ARGUMENT;
            end else if (is_get) begin
              line_kind  = KIND_GET;
              line_limit = LINE_MAX_BYTES - CMD_MAX_LETTERS - 2;
              nxt        = PH_ARGUMENT;
            end
            line_pos = 0;
          end
        end
      end
      PH_ARGUMENT: begin
        if (line_pos < line_limit - 1) begin
          if (!c[7]) begin
            emit       = c;
            emit_valid = 1'b1;
            line_pos++;
            nxt = (c == CH_CR) ? PH_AFTER_CR : PH_ARGUMENT;
          end else begin
            nxt = PH_ARG_ERROR;
          end
        end else if (line_pos == line_limit - 1) begin
          // limit reached: forced CR LF, input word dropped
          line_pos += 2;
          line_phase = PH_DONE;
          r.phase        = PH_DONE;
          r.command_kind = line_kind;
          r.arg_byte     = CH_CR[6:0];
          r.arg_valid    = 1'b1;
          r.last         = 1'b0;
          pending_results.push_back(r);
          r.arg_byte = CH_LF[6:0];
          r.last     = 1'b1;
          pending_results.push_back(r);
          return;
        end else begin
          nxt = PH_ARG_ERROR;
        end
      end
      PH_AFTER_CR: begin
        if (c == CH_LF) begin
          emit       = CH_LF;
          emit_valid = 1'b1;
          line_pos++;
          nxt = PH_DONE;
        end else if (c == CH_CR) begin
          nxt = PH_AFTER_CR;
        end else if (!c[7]) begin
          nxt = PH_ARGUMENT;
        end else begin
          nxt = PH_ARG_ERROR;
        end
      end
      PH_DONE, PH_ARG_ERROR, PH_CMD_ERROR: nxt = line_phase;
      default: nxt = PH_ARG_ERROR;
    endcase
    line_phase     = nxt;
    r.phase        = nxt;
    r.command_kind = line_kind;
    r.arg_byte     = emit[6:0];
    r.arg_valid    = emit_valid;
    r.last         = 1'b1;
    pending_results.push_back(r);
  endtask

  always @(posedge clk_i) begin
    clbp_result_t got;
    clbp_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {phase_o, command_kind_o, arg_byte_o, arg_valid_o, last_o};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual ph=%0d kind=%0d byte=%h v=%b last=%b",
                 $time, got.phase, got.command_kind, got.arg_byte, got.arg_valid, got.last);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (got.phase !== want.phase || got.command_kind !== want.command_kind ||
            got.arg_byte !== want.arg_byte || got.arg_valid !== want.arg_valid ||
            got.last !== want.last) begin
          $display("%0t: mismatch: expected ph=%0d kind=%0d byte=%h v=%b last=%b", $time,
                   want.phase, want.command_kind, want.arg_byte, want.arg_valid, want.last);
          $display("%0t:           actual   ph=%0d kind=%0d byte=%h v=%b last=%b", $time,
                   got.phase, got.command_kind, got.arg_byte, got.arg_valid, got.last);
          mismatches++;
        end
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_parse(b);
    @(negedge clk_i);
  endtask

  task automatic stop_sending();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Argument word, never LF right after CR so the line runs to its limit.
  function automatic logic [7:0] pick_arg_byte();
    logic [7:0] b;
    do begin
      b = ($urandom_range(9) == 0) ? CH_CR : 8'($urandom_range(127));
    end while (line_phase == PH_AFTER_CR && b == CH_LF);
    return b;
  endfunction

  task automatic test_command_word();
    string cmd;
    cmd = "eChO ";
    for (int i = 0; i < cmd.len(); i++) send_byte(cmd[i]);
    stop_sending();
  endtask

  task automatic test_argument_corners();
    send_byte(8'h00);
    send_byte(8'h7F);
    send_byte("A");
    send_byte(CH_CR);
    send_byte("x");   // lone non-LF after CR, not appended
    send_byte(CH_CR);
    send_byte(CH_CR); // repeated CR holds after-CR
    send_byte("z");
    send_byte("q");
    stop_sending();
  endtask

  task automatic test_argument_fill(input int target_pos);
    while (line_phase != PH_DONE && line_pos < target_pos) send_byte(pick_arg_byte());
    stop_sending();
  endtask

  task automatic test_output_hold();
    int saved_idle;
    saved_idle    = send_idle_pct;
    send_idle_pct = 0;
    fork
      begin
        @(posedge clk_i);
        hold_output = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_output = 1'b0;
      end
      repeat (12) send_byte(pick_arg_byte());
    join
    stop_sending();
    send_idle_pct = saved_idle;
  endtask

  task automatic test_done_hold(input int n);
    repeat (n) send_byte(8'($urandom_range(255)));
    stop_sending();
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_byte_i     = '0;
    hold_output   = 1'b0;
    send_idle_pct = 38;
    recv_idle_pct = 70;
    line_phase    = PH_COMMAND;
    line_pos      = 0;
    line_limit    = CMD_MAX_LETTERS;
    line_kind     = KIND_NONE;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_command_word();
    test_argument_corners();
    test_argument_fill(60);
    test_output_hold();

    send_idle_pct = 70;
    recv_idle_pct = 38;
    test_argument_fill(LINE_MAX_BYTES * 4);
    test_done_hold(300);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_done_hold(400);

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
